// ===== rtl/core/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types, constants and saturation helpers of the RLS ARX estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rls_pkg;

    localparam int NUM_COEFS = 4;
    localparam int OPND_W    = 48;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int DEN_W     = 63;
    localparam int CFG_W     = 47;

    localparam logic [16:0]        LAMBDA_RST   = 17'd64225;
    localparam logic [30:0]        THR_RST      = 31'd1310720;
    localparam logic [15:0]        BURST_RST    = 16'd100;
    localparam logic signed [47:0] COV_DIAG_RST = 48'sd16777216000;
    localparam logic signed [31:0] ONE_Q16      = 32'sd65536;

    typedef logic signed [OPND_W-1:0] t_p48;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef enum logic [1:0] {
        REG_LAMBDA,
        REG_COV_INIT,
        REG_THRESHOLD,
        REG_BURST
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_ACC,
        OP_DIV,
        OP_FIN,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        SEL_PRED,
        SEL_V,
        SEL_W,
        SEL_D,
        SEL_K,
        SEL_PK,
        SEL_T
    } t_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op        op;
        t_sel       sel;
        logic [1:0] i;
        logic [1:0] j;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic adapt;
        logic out_busy;
    } t_status;

    function automatic t_p48 sat48(input t_acc x);
        if (x[ACC_W-1:47] == '0 || x[ACC_W-1:47] == '1) begin
            return x[47:0];
        end
        return x[ACC_W-1] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32(input t_acc x);
        if (x[ACC_W-1:31] == '0 || x[ACC_W-1:31] == '1) begin
            return x[31:0];
        end
        return x[ACC_W-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rls_in_if.sv =====
// ----------------------------------------------------------------------------
// rls_in_if
// Sample channel: plant output, plant input and adaptation enable.
// ----------------------------------------------------------------------------
`default_nettype none

interface rls_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] plant_output;
    logic signed [31:0] plant_input;
    logic               adapt_enable;

    modport source (output valid, output plant_output, output plant_input,
                    output adapt_enable, input ready);
    modport sink   (input valid, input plant_output, input plant_input,
                    input adapt_enable, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rls_out_if.sv =====
// ----------------------------------------------------------------------------
// rls_out_if
// Result channel: prediction error, coefficient estimates and update flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rls_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] prediction_error;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic               adapted;

    modport source (output valid, output prediction_error, output coef_a1,
                    output coef_a2, output coef_b0, output coef_b1,
                    output adapted, input ready);
    modport sink   (input valid, input prediction_error, input coef_a1,
                    input coef_a2, input coef_b0, input coef_b1,
                    input adapted, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rls_arx_estimator_core.sv =====
// Samples are processed one at a time, with or without an update step, on the
// shared bit-serial 48x48 multiplier and the 96-step divider.
// A new sample is taken once the previous result sits in the output register.
// Synchronous active-low reset restores the registers, the covariance
// diagonal, the estimates (1.0, 0, 0, 0) and the history.
// ----------------------------------------------------------------------------
// rls_arx_estimator_core
// Recursive least squares identifier of a second-order ARX model with
// exponential forgetting, built as a sequencer and a fixed-point datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_arx_estimator_core import rls_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    rls_in_if.sink                i_sample,
    rls_out_if.source             o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    rls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_sample.ready = in_ready;

    rls_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_plant_output     (i_sample.plant_output),
        .i_plant_input      (i_sample.plant_input),
        .i_adapt_enable     (i_sample.adapt_enable),
        .o_valid            (o_result.valid),
        .i_ready            (o_result.ready),
        .o_prediction_error (o_result.prediction_error),
        .o_coef_a1          (o_result.coef_a1),
        .o_coef_a2          (o_result.coef_a2),
        .o_coef_b0          (o_result.coef_b0),
        .o_coef_b1          (o_result.coef_b1),
        .o_adapted          (o_result.adapted)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rls_mul.sv =====
// ----------------------------------------------------------------------------
// rls_mul
// Bit-serial signed 48 x 48 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_mul import rls_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_p48  i_a,
    input  wire t_p48  i_b,
    output logic       o_done,
    output t_prod      o_p
);
    localparam int CNT_W = $clog2(OPND_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic [OPND_W-1:0] r_ma, n_ma;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [OPND_W:0]   sum;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_ma   = r_ma;
        n_prod = r_prod;
        sum    = {1'b0, r_prod[PROD_W-1:OPND_W]} + (r_prod[0] ? {1'b0, r_ma} : '0);
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(OPND_W);
            n_neg  = i_a[OPND_W-1] ^ i_b[OPND_W-1];
            n_ma   = i_a[OPND_W-1] ? -i_a : i_a;
            n_prod = {{OPND_W{1'b0}}, (i_b[OPND_W-1] ? -i_b : i_b)};
        end else if (r_busy) begin
            n_prod = {sum, r_prod[OPND_W-1:1]};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg  <= n_neg;
        r_ma   <= n_ma;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_p    = r_neg ? -$signed(r_prod) : $signed(r_prod);

endmodule

`default_nettype wire

// ===== rtl/core/rls_div.sv =====
// ----------------------------------------------------------------------------
// rls_div
// Restoring divider: signed 96-bit numerator by unsigned divisor, quotient
// truncated toward zero and saturated to 48 bits, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_div import rls_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_prod            i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output t_p48                  o_q
);
    localparam int CNT_W = $clog2(PROD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W:0]    r_rem, n_rem;
    logic [PROD_W-1:0] r_m, n_m;
    logic [DEN_W:0]    shifted;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_den   = r_den;
        n_rem   = r_rem;
        n_m     = r_m;
        shifted = {r_rem[DEN_W-1:0], r_m[PROD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(PROD_W);
            n_neg  = i_num[PROD_W-1];
            n_den  = i_den;
            n_rem  = '0;
            n_m    = i_num[PROD_W-1] ? -i_num : i_num;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_den}) begin
                n_rem = shifted - {1'b0, r_den};
                n_m   = {r_m[PROD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_m   = {r_m[PROD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_den <= n_den;
        r_rem <= n_rem;
        r_m   <= n_m;
    end

    always_comb begin
        if (!r_neg) begin
            o_q = (|r_m[PROD_W-1:OPND_W-1]) ? {1'b0, {(OPND_W-1){1'b1}}} : r_m[OPND_W-1:0];
        end else if (|r_m[PROD_W-1:OPND_W] || (r_m[OPND_W-1] && |r_m[OPND_W-2:0])) begin
            o_q = {1'b1, {(OPND_W-1){1'b0}}};
        end else begin
            o_q = -r_m[OPND_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/rls_dp.sv =====
// ----------------------------------------------------------------------------
// rls_dp
// Estimator datapath: state, configuration, operand selection around one
// shared multiplier and one shared divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_dp import rls_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic signed [31:0] i_plant_output,
    input  wire logic signed [31:0] i_plant_input,
    input  wire logic               i_adapt_enable,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_prediction_error,
    output logic signed [31:0]      o_coef_a1,
    output logic signed [31:0]      o_coef_a2,
    output logic signed [31:0]      o_coef_b0,
    output logic signed [31:0]      o_coef_b1,
    output logic                    o_adapted
);
    logic [16:0]        r_lam;
    logic [30:0]        r_thr;
    logic [15:0]        r_ub;
    logic [15:0]        r_burst;
    t_p48               r_p [NUM_COEFS*NUM_COEFS];
    logic signed [31:0] r_th [NUM_COEFS];
    t_p48               r_v [NUM_COEFS];
    t_p48               r_w [NUM_COEFS];
    t_p48               r_k [NUM_COEFS];
    logic signed [32:0] r_phi [NUM_COEFS];
    logic signed [31:0] r_y, r_u, r_y1, r_y2, r_u1;
    logic               r_en;
    logic [DEN_W-1:0]   r_d;
    t_acc               r_acc;
    logic signed [31:0] r_eps;
    logic               r_adapt;
    logic               r_ovalid;
    logic signed [31:0] r_oerr, r_oa1, r_oa2, r_ob0, r_ob1;
    logic               r_oadapt;

    logic [3:0]         p_idx;
    t_p48               p_rd;
    t_p48               mul_a, mul_b;
    logic               mul_done, div_done;
    t_prod              prod;
    t_p48               div_q;
    t_prod              div_num;
    logic [DEN_W-1:0]   div_den;
    t_acc               acc_add, acc_sh, e, thr_s, d_sum, th_sum;
    t_prod              pk_sh, x96;
    logic               trig, adapt_now;
    logic [15:0]        bl;
    logic [16:0]        lam_eff;
    logic [DEN_W-1:0]   d_clamp;

    localparam t_acc D_MAX = t_acc'(64'sd4611686018427387904);

    assign p_idx   = (i_cmd.sel == SEL_W) ? {i_cmd.j, i_cmd.i} : {i_cmd.i, i_cmd.j};
    assign p_rd    = r_p[p_idx];
    assign lam_eff = (r_lam == '0) ? 17'd1 : r_lam;

    always_comb begin
        case (i_cmd.sel)
            SEL_PRED: begin
                mul_a = t_p48'(r_phi[i_cmd.j]);
                mul_b = t_p48'(r_th[i_cmd.j]);
            end
            SEL_V: begin
                mul_a = p_rd;
                mul_b = t_p48'(r_phi[i_cmd.j]);
            end
            SEL_W: begin
                mul_a = t_p48'(r_phi[i_cmd.j]);
                mul_b = p_rd;
            end
            SEL_D: begin
                mul_a = t_p48'(r_phi[i_cmd.j]);
                mul_b = r_v[i_cmd.j];
            end
            SEL_PK: begin
                mul_a = r_k[i_cmd.i];
                mul_b = r_w[i_cmd.j];
            end
            SEL_T: begin
                mul_a = r_k[i_cmd.i];
                mul_b = t_p48'(r_eps);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rls_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_MUL),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (prod)
    );

    assign pk_sh = prod >>> 24;
    assign x96   = t_prod'(p_rd) - pk_sh;

    always_comb begin
        if (i_cmd.sel == SEL_K) begin
            div_num = t_prod'(r_v[i_cmd.i]) <<< 24;
            div_den = r_d;
        end else begin
            div_num = x96 <<< 16;
            div_den = DEN_W'(lam_eff);
        end
    end

    rls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_comb begin
        acc_add   = ((i_cmd.j == 2'd0) ? t_acc'(0) : r_acc) + t_acc'(prod);
        acc_sh    = r_acc >>> 16;
        e         = t_acc'(r_y) - acc_sh;
        thr_s     = t_acc'({1'b0, r_thr});
        trig      = r_en && (e > thr_s || e < -thr_s);
        bl        = trig ? r_ub : r_burst;
        adapt_now = (bl != '0);
        d_sum     = acc_sh + t_acc'({1'b0, lam_eff, 8'b0});
        if (d_sum < t_acc'(1)) begin
            d_clamp = DEN_W'(1);
        end else if (d_sum > D_MAX) begin
            d_clamp = D_MAX[DEN_W-1:0];
        end else begin
            d_clamp = d_sum[DEN_W-1:0];
        end
        th_sum = t_acc'(r_th[i_cmd.i]) + t_acc'(pk_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam    <= LAMBDA_RST;
            r_thr    <= THR_RST;
            r_ub     <= BURST_RST;
            r_burst  <= '0;
            r_y1     <= '0;
            r_y2     <= '0;
            r_u1     <= '0;
            r_ovalid <= 1'b0;
            for (int n = 0; n < NUM_COEFS * NUM_COEFS; n++) begin
                r_p[n] <= (n % (NUM_COEFS + 1) == 0) ? COV_DIAG_RST : '0;
            end
            for (int n = 0; n < NUM_COEFS; n++) begin
                r_th[n] <= (n == 0) ? ONE_Q16 : '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_LAMBDA:    r_lam <= i_cfg_data[16:0];
                    REG_THRESHOLD: r_thr <= i_cfg_data[30:0];
                    REG_BURST:     r_ub  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_y    <= i_plant_output;
                    r_u    <= i_plant_input;
                    r_en   <= i_adapt_enable;
                    r_phi[0] <= -{r_y1[31], r_y1};
                    r_phi[1] <= -{r_y2[31], r_y2};
                    r_phi[2] <= {i_plant_input[31], i_plant_input};
                    r_phi[3] <= {r_u1[31], r_u1};
                end
                OP_ACC: r_acc <= acc_add;
                OP_FIN: begin
                    case (i_cmd.sel)
                        SEL_PRED: begin
                            r_eps   <= sat32(e);
                            r_adapt <= adapt_now;
                            r_burst <= adapt_now ? bl - 1'b1 : bl;
                        end
                        SEL_V:  r_v[i_cmd.i] <= sat48(acc_sh);
                        SEL_W:  r_w[i_cmd.i] <= sat48(acc_sh);
                        SEL_D:  r_d <= d_clamp;
                        SEL_K:  r_k[i_cmd.i] <= div_q;
                        SEL_PK: r_p[p_idx] <= div_q;
                        SEL_T:  r_th[i_cmd.i] <= sat32(th_sum);
                        default: ;
                    endcase
                end
                OP_OUT: begin
                    r_y2     <= r_y1;
                    r_y1     <= r_y;
                    r_u1     <= r_u;
                    r_oerr   <= r_eps;
                    r_oa1    <= r_th[0];
                    r_oa2    <= r_th[1];
                    r_ob0    <= r_th[2];
                    r_ob1    <= r_th[3];
                    r_oadapt <= r_adapt;
                end
                default: ;
            endcase
        end
    end

    assign o_status.mul_done = mul_done;
    assign o_status.div_done = div_done;
    assign o_status.adapt    = adapt_now;
    assign o_status.out_busy = r_ovalid && !i_ready;

    assign o_valid            = r_ovalid;
    assign o_prediction_error = r_oerr;
    assign o_coef_a1          = r_oa1;
    assign o_coef_a2          = r_oa2;
    assign o_coef_b0          = r_ob0;
    assign o_coef_b1          = r_ob1;
    assign o_adapted          = r_oadapt;

endmodule

`default_nettype wire

// ===== rtl/core/rls_ctrl.sv =====
// ----------------------------------------------------------------------------
// rls_ctrl
// Estimator sequencer over the shared units: prediction and, if adapting,
// covariance products, gain division, covariance and estimate update.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_ctrl import rls_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state     r_state, n_state;
    t_sel       r_sel, n_sel;
    logic [1:0] r_i, n_i;
    logic [1:0] r_j, n_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= SEL_PRED;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_i        = r_i;
        n_j        = r_j;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NOP;
        o_cmd.sel  = r_sel;
        o_cmd.i    = r_i;
        o_cmd.j    = r_j;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_sel    = SEL_PRED;
                    n_i      = '0;
                    n_j      = '0;
                    n_state  = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (i_status.mul_done) begin
                    if (r_sel == SEL_PK) begin
                        n_state = ST_DIV_GO;
                    end else if (r_sel == SEL_T) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_j == 2'd3) begin
                    n_state = ST_FIN;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_MUL_GO;
                end
            end
            ST_DIV_GO: begin
                o_cmd.op = OP_DIV;
                n_state  = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.op = OP_FIN;
                n_j      = '0;
                n_state  = ST_MUL_GO;
                case (r_sel)
                    SEL_PRED: begin
                        if (i_status.adapt) begin
                            n_sel = SEL_V;
                            n_i   = '0;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end
                    SEL_V: begin
                        n_i = r_i + 1'b1;
                        if (r_i == 2'd3) begin
                            n_sel = SEL_W;
                        end
                    end
                    SEL_W: begin
                        n_i = r_i + 1'b1;
                        if (r_i == 2'd3) begin
                            n_sel = SEL_D;
                        end
                    end
                    SEL_D: begin
                        n_sel   = SEL_K;
                        n_i     = '0;
                        n_state = ST_DIV_GO;
                    end
                    SEL_K: begin
                        n_i = r_i + 1'b1;
                        if (r_i == 2'd3) begin
                            n_sel = SEL_PK;
                        end else begin
                            n_state = ST_DIV_GO;
                        end
                    end
                    SEL_PK: begin
                        n_j = r_j + 1'b1;
                        if (r_j == 2'd3) begin
                            n_i = r_i + 1'b1;
                            if (r_i == 2'd3) begin
                                n_sel = SEL_T;
                            end
                        end
                    end
                    SEL_T: begin
                        n_i = r_i + 1'b1;
                        if (r_i == 2'd3) begin
                            n_state = ST_OUT;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/rls_arx_estimator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rls_arx_estimator_core_tb
// Self-checking bench for the RLS ARX estimator core. Samples from a simulated
// second-order plant, mixed with full-range noise, go through the sample
// channel under several configuration and flow-control phases. A bit-exact
// fixed-point estimator inside the bench predicts every result transaction.
// ----------------------------------------------------------------------------

module rls_arx_estimator_core_tb import rls_pkg::*; ();

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [31:0] y;
        logic signed [31:0] u;
        logic               en;
    } t_sample;

    typedef struct {
        logic signed [31:0] err;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic               adapted;
    } t_estimate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    rls_in_if  sample_ch ();
    rls_out_if result_ch ();

    rls_arx_estimator_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_ch.sink),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (result_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample   pending_samples[$];
    t_estimate expected_estimates[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;

    // Shadow copy of the estimator state and its registers.
    logic [16:0] lambda_q;
    logic [46:0] cov_init_q;
    logic [30:0] threshold_q;
    logic [15:0] burst_q;
    logic [15:0] burst_left;
    t_wide       cov[16];
    t_wide       theta[4];
    t_wide       y_hist1, y_hist2, u_hist1;

    // Plant used to build well-formed sample sequences.
    longint plant_y1, plant_y2, plant_u1;

    function automatic t_wide clip(t_wide x, int bits);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic void rls_gain_step(t_wide phi[4], t_wide eps);
        t_wide lam, sv, sw, acc, d, x;
        t_wide v[4], w[4], k[4];
        lam = (lambda_q == 0) ? t_wide'(1) : t_wide'({111'b0, lambda_q});
        for (int i = 0; i < 4; i++) begin
            sv = 0;
            sw = 0;
            for (int j = 0; j < 4; j++) begin
                sv += cov[i * 4 + j] * phi[j];
                sw += phi[j] * cov[j * 4 + i];
            end
            v[i] = clip(sv >>> 16, 48);
            w[i] = clip(sw >>> 16, 48);
        end
        acc = 0;
        for (int i = 0; i < 4; i++) acc += phi[i] * v[i];
        d = clip((acc >>> 16) + (lam <<< 8), 64);
        if (d < 1) d = 1;
        if (d > (t_wide'(1) <<< 62)) d = t_wide'(1) <<< 62;
        for (int i = 0; i < 4; i++) k[i] = clip((v[i] <<< 24) / d, 48);
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                x = cov[i * 4 + j] - ((k[i] * w[j]) >>> 24);
                cov[i * 4 + j] = clip((x <<< 16) / lam, 48);
            end
        end
        for (int i = 0; i < 4; i++) theta[i] = clip(theta[i] + ((k[i] * eps) >>> 24), 32);
    endfunction

    function automatic t_estimate rls_predict(t_sample s);
        t_estimate r;
        t_wide phi[4];
        t_wide acc, e, e64, e32, thr;
        phi[0] = -y_hist1;
        phi[1] = -y_hist2;
        phi[2] = t_wide'(s.u);
        phi[3] = u_hist1;
        acc = 0;
        for (int i = 0; i < 4; i++) acc += phi[i] * theta[i];
        e = t_wide'(s.y) - (acc >>> 16);
        e64 = clip(e, 64);
        e32 = clip(e, 32);
        thr = t_wide'({97'b0, threshold_q});
        if (s.en && (e64 > thr || e64 < -thr)) burst_left = burst_q;
        r.adapted = 1'b0;
        if (burst_left != 0) begin
            burst_left = burst_left - 16'd1;
            r.adapted = 1'b1;
            rls_gain_step(phi, e32);
        end
        y_hist2 = y_hist1;
        y_hist1 = t_wide'(s.y);
        u_hist1 = t_wide'(s.u);
        r.err = e32[31:0];
        r.a1 = theta[0][31:0];
        r.a2 = theta[1][31:0];
        r.b0 = theta[2][31:0];
        r.b1 = theta[3][31:0];
        return r;
    endfunction

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else if (!sample_ch.valid || sample_ch.ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_sample s;
                s = pending_samples.pop_front();
                sample_ch.valid        <= 1'b1;
                sample_ch.plant_output <= s.y;
                sample_ch.plant_input  <= s.u;
                sample_ch.adapt_enable <= s.en;
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Prediction on accepted samples and checking of result transactions.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                t_sample s;
                s.y = sample_ch.plant_output;
                s.u = sample_ch.plant_input;
                s.en = sample_ch.adapt_enable;
                expected_estimates.push_back(rls_predict(s));
            end
            if (result_ch.valid && result_ch.ready) begin
                t_estimate x;
                if (expected_estimates.size() == 0) begin
                    $error("result transaction with no sample pending");
                    error_count++;
                end else begin
                    x = expected_estimates.pop_front();
                    if (result_ch.prediction_error !== x.err) begin
                        $error("prediction_error exp %0d got %0d", x.err,
                               result_ch.prediction_error);
                        error_count++;
                    end
                    if (result_ch.coef_a1 !== x.a1) begin
                        $error("coef_a1 exp %0d got %0d", x.a1, result_ch.coef_a1);
                        error_count++;
                    end
                    if (result_ch.coef_a2 !== x.a2) begin
                        $error("coef_a2 exp %0d got %0d", x.a2, result_ch.coef_a2);
                        error_count++;
                    end
                    if (result_ch.coef_b0 !== x.b0) begin
                        $error("coef_b0 exp %0d got %0d", x.b0, result_ch.coef_b0);
                        error_count++;
                    end
                    if (result_ch.coef_b1 !== x.b1) begin
                        $error("coef_b1 exp %0d got %0d", x.b1, result_ch.coef_b1);
                        error_count++;
                    end
                    if (result_ch.adapted !== x.adapted) begin
                        $error("adapted exp %0b got %0b", x.adapted, result_ch.adapted);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= 200000) begin
            $display("FAIL rls_arx_estimator_core");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_LAMBDA:    lambda_q = value[16:0];
            REG_COV_INIT:  cov_init_q = value[46:0];
            REG_THRESHOLD: threshold_q = value[30:0];
            REG_BURST:     burst_q = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !sample_ch.valid && expected_estimates.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic push_sample(logic signed [31:0] y, logic signed [31:0] u, logic en);
        t_sample s;
        s.y = y;
        s.u = u;
        s.en = en;
        pending_samples.push_back(s);
    endtask

    // Mostly samples of a stable plant with small noise, the rest full-range noise.
    task automatic push_random(int count);
        longint y, u;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 80) begin
                u = longint'($urandom_range(262144)) - 131072;
                y = (78643 * plant_y1 - 32768 * plant_y2 + 19661 * u + 13107 * plant_u1) >>> 16;
                y += longint'($urandom_range(2000)) - 1000;
                if (y > 65536000) y = 65536000;
                if (y < -65536000) y = -65536000;
                plant_y2 = plant_y1;
                plant_y1 = y;
                plant_u1 = u;
                push_sample(y[31:0], u[31:0], $urandom_range(99) < 90);
            end else begin
                push_sample($urandom, $urandom, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.plant_output = '0;
        sample_ch.plant_input = '0;
        sample_ch.adapt_enable = 1'b0;
        result_ch.ready = 1'b0;
        lambda_q = LAMBDA_RST;
        cov_init_q = 47'(COV_DIAG_RST);
        threshold_q = THR_RST;
        burst_q = BURST_RST;
        burst_left = '0;
        for (int i = 0; i < 16; i++) cov[i] = (i % 5 == 0) ? t_wide'(COV_DIAG_RST) : '0;
        theta[0] = t_wide'(ONE_Q16);
        for (int i = 1; i < 4; i++) theta[i] = '0;
        y_hist1 = '0;
        y_hist2 = '0;
        u_hist1 = '0;
        plant_y1 = 0;
        plant_y2 = 0;
        plant_u1 = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes with the reset configuration.
        push_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
        push_sample(32'sh80000000, 32'sh80000000, 1'b1);
        push_sample('0, '0, 1'b0);
        push_sample(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        push_sample(-32'sd1, 32'sd1, 1'b1);
        push_sample(32'sd1, -32'sd1, 1'b0);
        push_sample(32'sh80000000, 32'sh7FFFFFFF, 1'b1);
        push_sample(32'sd1310721, '0, 1'b1);
        push_sample(-32'sd1310721, 32'sd65536, 1'b1);
        push_sample('0, '0, 1'b1);
        drain();

        // Zero burst and zero threshold: triggers without any update.
        write_reg(REG_BURST, '0);
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_COV_INIT, '0);
        push_sample(32'sh12345678, 32'sh0000FFFF, 1'b1);
        push_sample(32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        push_sample('0, '0, 1'b1);
        drain();

        // Zero forgetting factor and maximum threshold.
        write_reg(REG_LAMBDA, '0);
        write_reg(REG_THRESHOLD, 47'h7FFFFFFF);
        write_reg(REG_BURST, 47'd2);
        push_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
        push_sample(32'sh80000000, 32'sh80000000, 1'b1);
        push_sample(32'sh40000000, 32'shC0000000, 1'b1);
        push_sample('0, 32'sh7FFFFFFF, 1'b0);
        drain();

        // Random phases with varying flow control and registers.
        write_reg(REG_LAMBDA, LAMBDA_RST);
        write_reg(REG_THRESHOLD, THR_RST);
        write_reg(REG_BURST, 47'd4);
        push_random(420);
        drain();

        send_idle_pct = 81;
        write_reg(REG_LAMBDA, 47'd131071);
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_BURST, 47'd1);
        push_random(300);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 81;
        write_reg(REG_LAMBDA, '0);
        write_reg(REG_THRESHOLD, 47'h7FFFFFFF);
        write_reg(REG_BURST, 47'd3);
        push_random(300);
        drain();

        send_idle_pct = 38;
        recv_stall_pct = 38;
        write_reg(REG_LAMBDA, 47'd65535);
        write_reg(REG_THRESHOLD, 47'd65536);
        write_reg(REG_BURST, 47'd65535);
        push_random(200);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_COV_INIT, 47'h7FFFFFFFFFFF);
        write_reg(REG_LAMBDA, 47'd1);
        write_reg(REG_THRESHOLD, 47'd655360);
        write_reg(REG_BURST, '0);
        push_random(150);
        drain();

        write_reg(REG_LAMBDA, LAMBDA_RST);
        write_reg(REG_BURST, 47'd8);
        push_random(150);
        drain();
        repeat (100) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS rls_arx_estimator_core");
        end else begin
            $display("FAIL rls_arx_estimator_core");
        end
        $finish;
    end

endmodule
